>>> rtl/scd_pkg.sv
`default_nettype none
package scd_pkg;

   localparam int CYL_W      = 16;
   localparam int MOVE_W     = 17;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_START_HEAD     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_CYLINDERS = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_UP       = 8'd2;

   typedef logic [CYL_W-1:0]      cyl_type;
   typedef logic [MOVE_W-1:0]     move_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam cyl_type  START_HEAD_RESET = 16'd0;
   localparam cyl_type  END_CYL_RESET    = 16'd199;
   localparam cyl_type  END_CYL_MAX      = 16'hFFFF;
   localparam move_type MOVE_MAX         = 17'h1FFFF;

   typedef struct packed {
      cyl_type start_head;
      cyl_type end_cyl;
      logic    sweep_up;
   } cfg_type;

   function automatic cyl_type clamp_cyl(input cyl_type v, input cyl_type lim);
      return (v > lim) ? lim : v;
   endfunction

   // saturating running movement after a head move
   function automatic move_type add_travel(input move_type mov, input cyl_type from,
                                           input cyl_type to);
      cyl_type           gap;
      logic [MOVE_W:0]   sum;
      gap = (to > from) ? (to - from) : (from - to);
      sum = {1'b0, mov} + {2'b00, gap};
      return sum[MOVE_W] ? MOVE_MAX : sum[MOVE_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/scd_if.sv
`default_nettype none
interface scd_req_if;
   import scd_pkg::*;
   logic    valid;
   logic    ready;
   cyl_type request_cylinder;
   logic    batch_end;
   modport source (output valid, output request_cylinder, output batch_end, input ready);
   modport sink   (input valid, input request_cylinder, input batch_end, output ready);
endinterface

interface scd_rsp_if;
   import scd_pkg::*;
   logic     valid;
   logic     ready;
   cyl_type  served_cylinder;
   move_type movement_so_far;
   logic     order_end;
   modport source (output valid, output served_cylinder, output movement_so_far,
                   output order_end, input ready);
   modport sink   (input valid, input served_cylinder, input movement_so_far,
                   input order_end, output ready);
endinterface

interface scd_csr_if;
   import scd_pkg::*;
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/scd_csr.sv
`default_nettype none
module scd_csr (
   input  logic             clock,
   input  logic             reset,
   scd_csr_if.sink          csr_ch,
   output scd_pkg::cfg_type cfg
);
   import scd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_fire;
   cyl_type end_cyl;

   assign csr_ch.ready = 1'b1;
   assign wr_fire      = csr_ch.valid && csr_ch.ready;
   assign cfg          = cfg_ff;

   // last usable cylinder, disk size clipped to 1..65536
   always_comb begin
      if (csr_ch.data == '0) begin
         end_cyl = '0;
      end else if (csr_ch.data[CSR_DATA_W-1]) begin
         end_cyl = END_CYL_MAX;
      end else begin
         end_cyl = csr_ch.data[CYL_W-1:0] - cyl_type'(1);
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (csr_ch.index)
            CSR_START_HEAD:     cfg_in.start_head = csr_ch.data[CYL_W-1:0];
            CSR_DISK_CYLINDERS: cfg_in.end_cyl    = end_cyl;
            CSR_SWEEP_UP:       cfg_in.sweep_up   = csr_ch.data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_head <= START_HEAD_RESET;
         cfg_ff.end_cyl    <= END_CYL_RESET;
         cfg_ff.sweep_up   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/scd_store.sv
`default_nettype none
module scd_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  scd_pkg::cyl_type      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output scd_pkg::cyl_type      rd_data
);
   import scd_pkg::*;

   cyl_type mem [DEPTH];
   cyl_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/scan_disk_scheduler.sv
`default_nettype none
// channel   dir  handshake       payload
// req_ch    in   valid/ready     request_cylinder[15:0], batch_end
// rsp_ch    out  valid/ready     served_cylinder[15:0], movement_so_far[16:0], order_end
// csr_ch    in   valid/ready     index[7:0], data[16:0]
//
// a request into an empty store is written directly, a request into a full store is dropped,
// else it is a sorted insert: each stored entry above it is shifted up, then it is written
// a batch end then reads every stored request to find the split point, then reads and serves
// each item of a group in turn, with group steps between groups and a travel step to an end
// the store has one read and one write port, read data registered
// reset is synchronous; the store needs no clearing, only entries below the count are read
// a stalled rsp_ch holds the sequencer; csr_ch is always ready
module scan_disk_scheduler #(
   parameter int MAX_REQUESTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   scd_req_if.sink    req_ch,
   scd_rsp_if.source  rsp_ch,
   scd_csr_if.sink    csr_ch
);
   import scd_pkg::*;

   localparam int ADDR_W = $clog2(MAX_REQUESTS);
   localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_SHIFT, S_PLACE, S_SPLIT_RD, S_SPLIT_CMP,
      S_GROUP, S_RD, S_EMIT, S_NEXT, S_TRAVEL
   } state_type;

   cfg_type cfg;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  split_ff, split_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   cyl_type           val_ff, val_in;
   logic              last_ff, last_in;
   logic              second_ff, second_in;
   cyl_type           head_ff, head_in;
   move_type          mov_ff, mov_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cyl_type           rsp_cyl_ff, rsp_cyl_in;
   move_type          rsp_mov_ff, rsp_mov_in;
   logic              rsp_end_ff, rsp_end_in;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   cyl_type           mem_wdata, mem_rdata;

   logic              req_fire, emit_fire, ins_done, serve_start, use_upper;
   logic [CNT_W-1:0]  other_cnt;
   cyl_type           cur_cyl, travel_cyl;

   scd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   scd_store #(
      .DEPTH  (MAX_REQUESTS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ch.ready           = (state_ff == S_IDLE);
   assign req_fire               = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.served_cylinder = rsp_cyl_ff;
   assign rsp_ch.movement_so_far = rsp_mov_ff;
   assign rsp_ch.order_end       = rsp_end_ff;

   assign use_upper  = cfg.sweep_up ^ second_ff;
   assign other_cnt  = use_upper ? split_ff : (count_ff - split_ff);
   assign cur_cyl    = clamp_cyl(mem_rdata, cfg.end_cyl);
   assign travel_cyl = cfg.sweep_up ? cfg.end_cyl : '0;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      split_in     = split_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      second_in    = second_ff;
      head_in      = head_ff;
      mov_in       = mov_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_cyl_in   = rsp_cyl_ff;
      rsp_mov_in   = rsp_mov_ff;
      rsp_end_in   = rsp_end_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = val_ff;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff;
      emit_fire    = 1'b0;
      ins_done     = 1'b0;
      serve_start  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               val_in  = req_ch.request_cylinder;
               last_in = req_ch.batch_end;
               if (count_ff == CNT_MAX) begin
                  serve_start = req_ch.batch_end;
               end else if (count_ff == '0) begin
                  mem_we      = 1'b1;
                  mem_waddr   = '0;
                  mem_wdata   = req_ch.request_cylinder;
                  count_in    = CNT_ONE;
                  serve_start = req_ch.batch_end;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = ADDR_W'(count_ff - CNT_ONE);
                  idx_in    = count_ff[ADDR_W-1:0];
                  state_in  = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            if (mem_rdata > val_ff) begin
               mem_wdata = mem_rdata;
               if (idx_ff == ADDR_W'(1)) begin
                  state_in = S_PLACE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_ff - ADDR_W'(2);
                  idx_in    = idx_ff - ADDR_W'(1);
               end
            end else begin
               mem_wdata = val_ff;
               ins_done  = 1'b1;
            end
         end
         S_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = val_ff;
            ins_done  = 1'b1;
         end
         S_SPLIT_RD: begin
            mem_re   = 1'b1;
            state_in = S_SPLIT_CMP;
         end
         S_SPLIT_CMP: begin
            if (cur_cyl <= head_ff) begin
               split_in = split_ff + CNT_ONE;
            end
            if (CNT_W'(idx_ff) + CNT_ONE == count_ff) begin
               state_in = S_GROUP;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = S_SPLIT_RD;
            end
         end
         S_GROUP: begin
            if (use_upper) begin
               idx_in = split_ff[ADDR_W-1:0];
               rem_in = count_ff - split_ff;
            end else begin
               idx_in = ADDR_W'(split_ff - CNT_ONE);
               rem_in = split_ff;
            end
            state_in = (rem_in == '0) ? S_NEXT : S_RD;
         end
         S_RD: begin
            mem_re   = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               emit_fire    = 1'b1;
               head_in      = cur_cyl;
               mov_in       = add_travel(mov_ff, head_ff, cur_cyl);
               rsp_valid_in = 1'b1;
               rsp_cyl_in   = cur_cyl;
               rsp_mov_in   = mov_in;
               rsp_end_in   = (rem_ff == CNT_ONE) && (second_ff || other_cnt == '0);
               rem_in       = rem_ff - CNT_ONE;
               if (rem_ff == CNT_ONE) begin
                  state_in = S_NEXT;
               end else begin
                  idx_in   = use_upper ? (idx_ff + ADDR_W'(1)) : (idx_ff - ADDR_W'(1));
                  state_in = S_RD;
               end
            end
         end
         S_NEXT: begin
            if (!second_ff && other_cnt != '0) begin
               second_in = 1'b1;
               state_in  = S_TRAVEL;
            end else begin
               count_in = '0;
               state_in = S_IDLE;
            end
         end
         S_TRAVEL: begin
            head_in  = travel_cyl;
            mov_in   = add_travel(mov_ff, head_ff, travel_cyl);
            state_in = S_GROUP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ins_done) begin
         count_in = count_ff + CNT_ONE;
         if (last_ff) begin
            serve_start = 1'b1;
         end else begin
            state_in = S_IDLE;
         end
      end

      if (serve_start) begin
         state_in  = S_SPLIT_RD;
         head_in   = cfg.start_head;
         mov_in    = '0;
         idx_in    = '0;
         split_in  = '0;
         second_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      split_ff   <= split_in;
      rem_ff     <= rem_in;
      idx_ff     <= idx_in;
      val_ff     <= val_in;
      last_ff    <= last_in;
      second_ff  <= second_in;
      head_ff    <= head_in;
      mov_ff     <= mov_in;
      rsp_cyl_ff <= rsp_cyl_in;
      rsp_mov_ff <= rsp_mov_in;
      rsp_end_ff <= rsp_end_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("request count beyond store depth");

   a_head_follows: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> head_ff == rsp_cyl_ff)
      else $error("head position does not match served cylinder");

   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      emit_fire && rsp_end_in |=> state_ff == S_NEXT ##1 (state_ff == S_IDLE && count_ff == '0))
      else $error("batch not closed after last served item");

   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_EMIT) |-> rem_ff != '0)
      else $error("read issued with no item left in group");

endmodule
`default_nettype wire

>>> test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import scd_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int HOLD_OFF    = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int IDLE_PCT    = 37;
   localparam int RANDOM_ITEMS = 150;

   // indexes that decode to no register
   localparam csr_idx_type CSR_SPARE     = 8'd3;
   localparam csr_idx_type CSR_SPARE_TOP = 8'hFF;

   typedef struct packed {
      cyl_type cylinder;
      logic    batch_end;
   } request_type;

   typedef struct packed {
      cyl_type  served_cylinder;
      move_type movement_so_far;
      logic     order_end;
   } service_type;

   logic clock = 1'b0;
   logic reset;

   scd_req_if req_ch();
   scd_rsp_if rsp_ch();
   scd_csr_if csr_ch();

   scan_disk_scheduler #(.MAX_REQUESTS(STORE_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   request_type request_q[$];
   cyl_type     batch_store[$];
   service_type served_q[$];
   request_type next_req;
   service_type next_due;

   cyl_type      cfg_head  = START_HEAD_RESET;
   csr_data_type cfg_disk  = csr_data_type'(END_CYL_RESET) + csr_data_type'(1);
   logic         cfg_sweep = 1'b1;

   int unsigned requests_sent  = 0;
   int unsigned requests_taken = 0;
   int unsigned mismatches     = 0;
   int unsigned stall_cycles   = 0;
   bit          steady         = 1'b0;

   function automatic int unsigned usable_cylinders();
      int unsigned dc;
      dc = cfg_disk;
      if (dc == 0) dc = 1;
      if (dc > 65536) dc = 65536;
      return dc;
   endfunction

   // elevator order of the stored batch, with running head movement
   function automatic void plan_scan_order();
      int unsigned endc;
      int unsigned head;
      int unsigned mov;
      int          split;
      int          i;
      int unsigned sorted[$];
      int unsigned stops[$];
      bit          emit[$];
      service_type batch_out[$];
      endc = usable_cylinders() - 1;
      foreach (batch_store[k]) sorted.push_back((batch_store[k] > endc) ? endc : batch_store[k]);
      sorted.sort();
      head  = cfg_head;
      mov   = 0;
      split = 0;
      while (split < sorted.size() && sorted[split] <= head) split++;
      if (cfg_sweep) begin
         for (i = split; i < sorted.size(); i++) begin
            stops.push_back(sorted[i]);
            emit.push_back(1'b1);
         end
         if (split > 0) begin
            stops.push_back(endc);
            emit.push_back(1'b0);
         end
         for (i = split - 1; i >= 0; i--) begin
            stops.push_back(sorted[i]);
            emit.push_back(1'b1);
         end
      end else begin
         for (i = split - 1; i >= 0; i--) begin
            stops.push_back(sorted[i]);
            emit.push_back(1'b1);
         end
         if (split < sorted.size()) begin
            stops.push_back(0);
            emit.push_back(1'b0);
         end
         for (i = split; i < sorted.size(); i++) begin
            stops.push_back(sorted[i]);
            emit.push_back(1'b1);
         end
      end
      foreach (stops[s]) begin
         mov += (stops[s] > head) ? stops[s] - head : head - stops[s];
         if (mov > MOVE_MAX) mov = MOVE_MAX;
         head = stops[s];
         if (emit[s])
            batch_out.push_back('{served_cylinder: cyl_type'(head),
                                  movement_so_far: move_type'(mov), order_end: 1'b0});
      end
      batch_out[batch_out.size() - 1].order_end = 1'b1;
      served_q = {served_q, batch_out};
      batch_store.delete();
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s expected %0d actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            requests_taken++;
            if (batch_store.size() < STORE_DEPTH) batch_store.push_back(req_ch.request_cylinder);
            if (req_ch.batch_end) plan_scan_order();
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (request_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               next_req = request_q.pop_front();
               req_ch.valid            <= 1'b1;
               req_ch.request_cylinder <= next_req.cylinder;
               req_ch.batch_end        <= next_req.batch_end;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result sink
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (served_q.size() == 0) begin
            $display("%0t unexpected item: served_cylinder %0d movement_so_far %0d order_end %0b",
                     $time, rsp_ch.served_cylinder, rsp_ch.movement_so_far, rsp_ch.order_end);
            mismatches++;
         end else begin
            next_due = served_q.pop_front();
            check_field("served_cylinder", 32'(next_due.served_cylinder),
                        32'(rsp_ch.served_cylinder));
            check_field("movement_so_far", 32'(next_due.movement_so_far),
                        32'(rsp_ch.movement_so_far));
            check_field("order_end", 32'(next_due.order_end), 32'(rsp_ch.order_end));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_csr(input csr_idx_type idx, input csr_data_type value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_START_HEAD:     cfg_head  = value[CYL_W-1:0];
         CSR_DISK_CYLINDERS: cfg_disk  = value;
         CSR_SWEEP_UP:       cfg_sweep = value[0];
         default: ;
      endcase
   endtask

   task automatic add_request(input cyl_type cyl, input logic fin);
      request_q.push_back('{cylinder: cyl, batch_end: fin});
      requests_sent++;
   endtask

   // wait for the batch to drain, then let the sequencer go quiet
   task automatic settle();
      do @(posedge clock);
      while (requests_taken != requests_sent || served_q.size() != 0);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic queue_random_batch(input int unsigned count);
      int unsigned endc;
      int unsigned k;
      cyl_type     prev;
      cyl_type     pick;
      endc = usable_cylinders() - 1;
      prev = cfg_head;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(9))
            0: pick = cyl_type'($urandom_range(65535));
            1: pick = cfg_head;
            2: pick = prev;
            3: pick = '0;
            4: pick = cyl_type'(endc);
            5: pick = cyl_type'($urandom_range(endc, 65535));
            default: pick = cyl_type'($urandom_range(0, endc));
         endcase
         add_request(pick, k == count - 1);
         prev = pick;
      end
   endtask

   initial begin
      int unsigned  random_items;
      int unsigned  phase;
      int unsigned  batches;
      int unsigned  b;
      int unsigned  size;
      csr_data_type disk;
      cyl_type      head;

      reset               <= 1'b1;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= CSR_START_HEAD;
      csr_ch.data         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: clamping, equal requests, request at the head
      add_request(16'd10, 1'b0);
      add_request(16'd0, 1'b0);
      add_request(16'd199, 1'b0);
      add_request(16'd65535, 1'b0);
      add_request(16'd10, 1'b0);
      add_request(16'd150, 1'b1);
      settle();

      // downward sweep, then a single request batch
      write_csr(CSR_DISK_CYLINDERS, 17'd65536);
      write_csr(CSR_START_HEAD, 17'd100);
      write_csr(CSR_SWEEP_UP, 17'd0);
      add_request(16'd100, 1'b0);
      add_request(16'd0, 1'b0);
      add_request(16'd65535, 1'b0);
      add_request(16'd200, 1'b1);
      add_request(16'd42, 1'b1);
      settle();

      // zero disk size, head far beyond the disk
      write_csr(CSR_DISK_CYLINDERS, 17'd0);
      write_csr(CSR_START_HEAD, 17'd65535);
      write_csr(CSR_SWEEP_UP, 17'd1);
      add_request(16'd5, 1'b0);
      add_request(16'd0, 1'b1);
      settle();

      // oversized disk value, full-width travel both ways
      write_csr(CSR_DISK_CYLINDERS, 17'h1FFFF);
      write_csr(CSR_START_HEAD, 17'd0);
      write_csr(CSR_SPARE, csr_data_type'($urandom_range(131071)));
      write_csr(CSR_SPARE_TOP, csr_data_type'($urandom_range(131071)));
      add_request(16'd65535, 1'b0);
      add_request(16'd0, 1'b0);
      add_request(16'd0, 1'b1);
      settle();

      // single-cylinder disk, upper data bits ignored
      write_csr(CSR_DISK_CYLINDERS, 17'd1);
      write_csr(CSR_SWEEP_UP, 17'h1FFFE);
      write_csr(CSR_START_HEAD, 17'h1FFFF);
      add_request(16'd3, 1'b0);
      add_request(16'd7, 1'b1);
      settle();

      write_csr(CSR_DISK_CYLINDERS, 17'd65536);
      write_csr(CSR_START_HEAD, 17'd32768);
      add_request(16'd0, 1'b0);
      add_request(16'd65535, 1'b0);
      add_request(16'd32768, 1'b1);
      settle();

      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(7))
               0: disk = '0;
               1: disk = 17'd1;
               2: disk = 17'd65536;
               3: disk = csr_data_type'($urandom_range(65537, 131071));
               4: disk = csr_data_type'($urandom_range(2, 65535));
               default: disk = csr_data_type'($urandom_range(2, 400));
            endcase
            write_csr(CSR_DISK_CYLINDERS, disk);
         end
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(4))
               0: head = '0;
               1: head = 16'hFFFF;
               2: head = cyl_type'($urandom_range(65535));
               default: head = cyl_type'($urandom_range(0, usable_cylinders() - 1));
            endcase
            write_csr(CSR_START_HEAD, {1'($urandom_range(1)), head});
         end
         if ($urandom_range(3) != 0)
            write_csr(CSR_SWEEP_UP, {16'($urandom_range(65535)), 1'($urandom_range(1))});

         steady  = (phase == 2);
         batches = steady ? 3 : $urandom_range(1, 3);
         for (b = 0; b < batches; b++) begin
            if (b == 0 && phase == 1) size = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
            else if (b == 0 && phase == 4) size = STORE_DEPTH;
            else if (steady) size = $urandom_range(15, 30);
            else begin
               case ($urandom_range(9))
                  0: size = 1;
                  1: size = $urandom_range(20, 40);
                  default: size = $urandom_range(2, 10);
               endcase
            end
            queue_random_batch(size);
            random_items += size;
         end
         settle();
         steady = 1'b0;
         phase++;
      end

      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
